@@ rtl/eikonal_triangle_local_update_top_macros.svh @@
// assertion helpers for the asserting top module
`ifndef EIKONAL_TRIANGLE_LOCAL_UPDATE_TOP_MACROS_SVH
`define EIKONAL_TRIANGLE_LOCAL_UPDATE_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define ETLU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define ETLU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/etlu_pkg.sv @@
package etlu_pkg;

  // internal signed fixed point word
  typedef logic signed [63:0] q_t;

  localparam q_t QMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] QMAX_X = 65'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] QMIN_X = -65'sh0_7FFF_FFFF_FFFF_FFFF;

  // square root iterations, one result bit each
  localparam int SQRT_STEPS = 44;

  // case codes reported with each result
  localparam logic [3:0] CASE_BOTH_INF    = 4'd0;
  localparam logic [3:0] CASE_ONLY_SECOND = 4'd1;
  localparam logic [3:0] CASE_ONLY_FIRST  = 4'd2;
  localparam logic [3:0] CASE_DEGENERATE  = 4'd3;
  localparam logic [3:0] CASE_LINEAR      = 4'd4;
  localparam logic [3:0] CASE_NEG_DISC    = 4'd5;
  localparam logic [3:0] CASE_TWO_ROOTS   = 4'd6;
  localparam logic [3:0] CASE_ONE_ROOT    = 4'd7;
  localparam logic [3:0] CASE_NO_ROOT     = 4'd8;

  // branch decisions made early in the pipe
  typedef struct packed {
    logic small_a;
    logic small_b;
    logic neg_disc;
    logic no_root;
  } sel_t;

  // saturating add within +-QMAX
  function automatic q_t sadd(q_t a, q_t b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > QMAX_X) return QMAX;
    if (s < QMIN_X) return -QMAX;
    return $signed(s[63:0]);
  endfunction

  // magnitude of a value within +-QMAX
  function automatic logic [63:0] qmag(q_t a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

endpackage

@@ rtl/eikonal_triangle_local_update_top.sv @@
// Eikonal local update on one triangle: each input transfer carries two known
// vertices with arrival times and a target vertex, and one result transfer
// returns the arrival time at the target with a code for the case taken.
// Fully pipelined: one triangle is accepted every cycle while the output is not
// stalled. The pipe depth is set by the serial chain of a bit-per-stage square
// root (44 stages), a bit-per-stage divider after it and the final square root
// of the distance to the chosen root. A stalled output stalls the whole pipe;
// nothing is dropped or repeated. No transfer is taken during reset.
`include "eikonal_triangle_local_update_top_macros.svh"

module eikonal_triangle_local_update_top import etlu_pkg::*; #(
  parameter int FRAC_BITS   = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic clk,
  input  logic rst_n,
  // fields low to high: first_x, first_y, first_z, second_x, second_y,
  // second_z, target_x, target_y, target_z, first_time, second_time
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((11*VALUE_WIDTH+7)/8)*8-1:0]    in_tdata,
  // fields low to high: target_time
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [((VALUE_WIDTH+7)/8)*8-1:0]       out_tdata,
  // fields low to high: case_taken
  output logic [3:0]                             out_tuser,
  // degenerate_threshold
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [15:0]                            cfg_data
);

  localparam int VW    = VALUE_WIDTH;
  localparam int OUT_W = ((VALUE_WIDTH + 7) / 8) * 8;
  localparam int SQ    = SQRT_STEPS;
  localparam int DV    = 64 + FRAC_BITS;
  localparam int TL    = 10 + SQ + DV;
  localparam int LAST  = TL + 9 + SQ;
  localparam logic [63:0] VMASK64 = (64'd1 << VALUE_WIDTH) - 64'd1;

  logic            en;
  logic [LAST:0]   vld_r;
  logic [15:0]     thr_r;

  // configuration register
  assign cfg_ready = rst_n;
  always_ff @(posedge clk) begin
    if (!rst_n) thr_r <= 16'd1;
    else if (cfg_valid) thr_r <= cfg_data;
  end

  // pipe advances unless the output holds a result not yet taken
  assign en        = !vld_r[LAST] || out_tready;
  assign in_tready = en && rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[LAST-1:0], in_tvalid};
  end

  // unpack fields
  logic [VW-1:0] fld [11];
  q_t            vin [9];
  always_comb begin
    for (int k = 0; k < 11; k++) fld[k] = in_tdata[k*VW +: VW];
    for (int k = 0; k < 9; k++)  vin[k] = 64'($signed(fld[k]));
  end

  // T0: edge vectors and time difference
  q_t   u_r [3], w_r [3], e_r [3];
  q_t   phi_r, t1_r, t2_r;
  logic inf1_r, inf2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        u_r[k] <= vin[3+k] - vin[k];
        w_r[k] <= vin[6+k] - vin[k];
        e_r[k] <= vin[6+k] - vin[3+k];
      end
      t1_r   <= $signed(64'(fld[9]));
      t2_r   <= $signed(64'(fld[10]));
      phi_r  <= $signed(64'(fld[10])) - $signed(64'(fld[9]));
      inf1_r <= &fld[9];
      inf2_r <= &fld[10];
    end
  end

  // T0 -> T2 products: squares, dot terms, phi^2, cross terms
  q_t m0a [19], m0b [19], m0p [19];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      m0a[k]   = e_r[k]; m0b[k]   = e_r[k];
      m0a[3+k] = w_r[k]; m0b[3+k] = w_r[k];
      m0a[6+k] = u_r[k]; m0b[6+k] = u_r[k];
      m0a[9+k] = w_r[k]; m0b[9+k] = u_r[k];
    end
    m0a[12] = phi_r; m0b[12] = phi_r;
    m0a[13] = w_r[1]; m0b[13] = u_r[2];
    m0a[14] = w_r[2]; m0b[14] = u_r[1];
    m0a[15] = w_r[2]; m0b[15] = u_r[0];
    m0a[16] = w_r[0]; m0b[16] = u_r[2];
    m0a[17] = w_r[0]; m0b[17] = u_r[1];
    m0a[18] = w_r[1]; m0b[18] = u_r[0];
  end

  for (genvar g = 0; g < 19; g++) begin : g_m0
    etlu_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clk(clk), .en(en), .a(m0a[g]), .b(m0b[g]), .p(m0p[g]));
  end

  // T3: partial sums and cross product
  q_t ee01_r, ee2_r, ww01_r, ww2_r, uu01_r, uu2_r, wu01_r, wu2_r, ph2_3_r;
  q_t cr_r [3];
  always_ff @(posedge clk) begin
    if (en) begin
      ee01_r  <= sadd(m0p[0], m0p[1]);  ee2_r <= m0p[2];
      ww01_r  <= sadd(m0p[3], m0p[4]);  ww2_r <= m0p[5];
      uu01_r  <= sadd(m0p[6], m0p[7]);  uu2_r <= m0p[8];
      wu01_r  <= sadd(m0p[9], m0p[10]); wu2_r <= m0p[11];
      ph2_3_r <= m0p[12];
      cr_r[0] <= sadd(m0p[13], -m0p[14]);
      cr_r[1] <= sadd(m0p[15], -m0p[16]);
      cr_r[2] <= sadd(m0p[17], -m0p[18]);
    end
  end

  // T4: |e|^2, |w|^2, S, P
  q_t ne2_r, w2_r, s4_r, p4_r, ph2_4_r;
  always_ff @(posedge clk) begin
    if (en) begin
      ne2_r   <= sadd(ee01_r, ee2_r);
      w2_r    <= sadd(ww01_r, ww2_r);
      s4_r    <= sadd(uu01_r, uu2_r);
      p4_r    <= sadd(wu01_r, wu2_r);
      ph2_4_r <= ph2_3_r;
    end
  end

  // T3 -> T5 cross squares, T6/T7 sum to |w x u|^2
  q_t crsq [3];
  q_t x2a_r, x2b_r, x2_r;
  for (genvar g = 0; g < 3; g++) begin : g_cr
    etlu_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clk(clk), .en(en), .a(cr_r[g]), .b(cr_r[g]), .p(crsq[g]));
  end
  always_ff @(posedge clk) begin
    if (en) begin
      x2a_r <= sadd(crsq[0], crsq[1]);
      x2b_r <= crsq[2];
      x2_r  <= sadd(x2a_r, x2b_r);
    end
  end

  // T4 -> T6: phi^2 |w|^2 and P^2
  q_t ca_p, pp_p;
  etlu_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_ca (
    .clk(clk), .en(en), .a(ph2_4_r), .b(w2_r), .p(ca_p));
  etlu_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_pp (
    .clk(clk), .en(en), .a(p4_r), .b(p4_r), .p(pp_p));

  // T5: D = phi^2 - S
  q_t d5_r, s5_r, p5_r;
  always_ff @(posedge clk) begin
    if (en) begin
      d5_r <= sadd(ph2_4_r, -s4_r);
      s5_r <= s4_r;
      p5_r <= p4_r;
    end
  end

  // T5 -> T7: A = S D and P D
  q_t a_p, pd_p;
  etlu_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_a (
    .clk(clk), .en(en), .a(s5_r), .b(d5_r), .p(a_p));
  etlu_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_pd (
    .clk(clk), .en(en), .a(p5_r), .b(d5_r), .p(pd_p));

  // T6 .. T9: coefficients and branch flags
  q_t   negd6_r, c7_r, b8_r, negc8_r;
  logic dpos6_r, dneg6_r, nr6_r, dpos7_r, nr7_r, nr8_r, sa8_r, nd8_r;
  logic phinz7;
  sel_t sel9_r;

  etlu_dly #(.W(1), .N(7)) u_dly_phinz (
    .clk(clk), .en(en), .d(phi_r != 64'sd0), .q(phinz7));

  always_ff @(posedge clk) begin
    if (en) begin
      negd6_r <= -d5_r;
      dpos6_r <= d5_r > 64'sd0;
      dneg6_r <= d5_r[63];
      nr6_r   <= (s5_r == 64'sd0) || (d5_r == 64'sd0);
      c7_r    <= sadd(ca_p, -pp_p);
      dpos7_r <= dpos6_r;
      nr7_r   <= nr6_r;
      b8_r    <= -sadd(pd_p, pd_p);
      negc8_r <= -c7_r;
      sa8_r   <= qmag(a_p) < 64'(thr_r);
      nd8_r   <= dpos7_r && phinz7 && (x2_r > 64'sd0);
      nr8_r   <= nr7_r;
      sel9_r  <= '{small_a: sa8_r, small_b: qmag(b8_r) < 64'(thr_r),
                   neg_disc: nd8_r, no_root: nr8_r};
    end
  end

  // linear root -C/B
  q_t lin_q, lin_l;
  etlu_div #(.FRAC_BITS(FRAC_BITS)) u_div_lin (
    .clk(clk), .en(en), .n(negc8_r), .d(b8_r), .q(lin_q));
  etlu_dly #(.W(64), .N(2 + SQ)) u_dly_lin (
    .clk(clk), .en(en), .d(lin_q), .q(lin_l));

  // edge times through each known vertex
  q_t nw_q, ne_q, t1_e, t2_e, ea_r, eb_r;
  etlu_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt_w (
    .clk(clk), .en(en), .x(w2_r), .y(nw_q));
  etlu_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt_e (
    .clk(clk), .en(en), .x(ne2_r), .y(ne_q));
  etlu_dly #(.W(128), .N(4 + SQ)) u_dly_te (
    .clk(clk), .en(en), .d({t2_r, t1_r}), .q({t2_e, t1_e}));
  always_ff @(posedge clk) begin
    if (en) begin
      ea_r <= sadd(t1_e, nw_q);
      eb_r <= sadd(t2_e, ne_q);
    end
  end

  // root offset numerator |phi| |w x u| and denominator S sqrt(-D)
  q_t sqx_q, sqd_q, sqd_d, s51, s53, p53, absphi51, num_p, den_p;
  etlu_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt_x (
    .clk(clk), .en(en), .x(x2_r), .y(sqx_q));
  etlu_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt_d (
    .clk(clk), .en(en), .x(negd6_r), .y(sqd_q));
  etlu_dly #(.W(64), .N(1)) u_dly_sqd (
    .clk(clk), .en(en), .d(sqd_q), .q(sqd_d));
  etlu_dly #(.W(64), .N(3 + SQ)) u_dly_s51 (
    .clk(clk), .en(en), .d(s4_r), .q(s51));
  etlu_dly #(.W(64), .N(2)) u_dly_s53 (
    .clk(clk), .en(en), .d(s51), .q(s53));
  etlu_dly #(.W(64), .N(5 + SQ)) u_dly_p53 (
    .clk(clk), .en(en), .d(p4_r), .q(p53));
  etlu_dly #(.W(64), .N(7 + SQ)) u_dly_aphi (
    .clk(clk), .en(en), .d(phi_r[63] ? -phi_r : phi_r), .q(absphi51));
  etlu_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_num (
    .clk(clk), .en(en), .a(absphi51), .b(sqx_q), .p(num_p));
  etlu_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_den (
    .clk(clk), .en(en), .a(s51), .b(sqd_d), .p(den_p));

  // P/S and offset quotients
  q_t m_q, off_q;
  logic dneg_l;
  etlu_div #(.FRAC_BITS(FRAC_BITS)) u_div_m (
    .clk(clk), .en(en), .n(p53), .d(s53), .q(m_q));
  etlu_div #(.FRAC_BITS(FRAC_BITS)) u_div_off (
    .clk(clk), .en(en), .n(num_p), .d(den_p), .q(off_q));
  etlu_dly #(.W(1), .N(3 + SQ + DV)) u_dly_dneg (
    .clk(clk), .en(en), .d(dneg6_r), .q(dneg_l));

  // TL: the two quadratic roots
  q_t   l1_r, l2_r, offm;
  logic in1_r, in2_r, in1_e, in2_e;
  assign offm = dneg_l ? off_q : 64'sd0;
  always_ff @(posedge clk) begin
    if (en) begin
      l1_r  <= sadd(m_q, -offm);
      l2_r  <= sadd(m_q, offm);
      in1_r <= (l1_r > 64'sd0) && (l1_r < (64'sd1 <<< FRAC_BITS));
      in2_r <= (l2_r > 64'sd0) && (l2_r < (64'sd1 <<< FRAC_BITS));
    end
  end
  etlu_dly #(.W(2), .N(7 + SQ)) u_dly_in (
    .clk(clk), .en(en), .d({in2_r, in1_r}), .q({in2_e, in1_e}));

  // geometry carried to the root lanes
  q_t ul [3], wl [3], phil, t1l;
  etlu_dly #(.W(256), .N(TL)) u_dly_up (
    .clk(clk), .en(en), .d({phi_r, u_r[2], u_r[1], u_r[0]}),
    .q({phil, ul[2], ul[1], ul[0]}));
  etlu_dly #(.W(256), .N(TL + 2)) u_dly_wt (
    .clk(clk), .en(en), .d({t1_r, w_r[2], w_r[1], w_r[0]}),
    .q({t1l, wl[2], wl[1], wl[0]}));

  // time through a root: lane 0 l1, lane 1 l2, lane 2 linear root
  q_t lam [3], tres [3];
  assign lam[0] = l1_r;
  assign lam[1] = l2_r;
  assign lam[2] = lin_l;

  for (genvar g = 0; g < 3; g++) begin : g_lane
    q_t lu [3], tsq [3];
    q_t lphi, base_e, nrm;
    q_t t_r [3];
    q_t base_r, sa_r, sb_r, ssum_r, res_r;
    for (genvar k = 0; k < 3; k++) begin : g_k
      etlu_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_lu (
        .clk(clk), .en(en), .a(lam[g]), .b(ul[k]), .p(lu[k]));
      etlu_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_sq (
        .clk(clk), .en(en), .a(t_r[k]), .b(t_r[k]), .p(tsq[k]));
    end
    etlu_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_lp (
      .clk(clk), .en(en), .a(lam[g]), .b(phil), .p(lphi));
    always_ff @(posedge clk) begin
      if (en) begin
        for (int k = 0; k < 3; k++) t_r[k] <= sadd(wl[k], -lu[k]);
        base_r <= sadd(lphi, t1l);
        sa_r   <= sadd(tsq[0], tsq[1]);
        sb_r   <= tsq[2];
        ssum_r <= sadd(sa_r, sb_r);
        res_r  <= sadd(base_e, nrm);
      end
    end
    etlu_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt_t (
      .clk(clk), .en(en), .x(ssum_r), .y(nrm));
    etlu_dly #(.W(64), .N(SQ + 4)) u_dly_base (
      .clk(clk), .en(en), .d(base_r), .q(base_e));
    assign tres[g] = res_r;
  end

  // decisions carried to the output stage
  sel_t sel_e;
  logic inf1_e, inf2_e;
  q_t   ea_e, eb_e;
  etlu_dly #(.W($bits(sel_t)), .N(TL + SQ - 1)) u_dly_sel (
    .clk(clk), .en(en), .d(sel9_r), .q(sel_e));
  etlu_dly #(.W(2), .N(TL + 8 + SQ)) u_dly_inf (
    .clk(clk), .en(en), .d({inf2_r, inf1_r}), .q({inf2_e, inf1_e}));
  etlu_dly #(.W(128), .N(TL + 3)) u_dly_ee (
    .clk(clk), .en(en), .d({eb_r, ea_r}), .q({eb_e, ea_e}));

  // output stage: pick the case, clamp and saturate
  logic [VW-1:0] out_time_r, out_time_nxt;
  logic [3:0]    out_case_r, out_case_nxt;
  always_comb begin
    q_t emin, rsel, rcl;
    emin = (ea_e < eb_e) ? ea_e : eb_e;
    rsel = emin;
    out_case_nxt = CASE_NO_ROOT;
    if (inf1_e && inf2_e) begin
      out_case_nxt = CASE_BOTH_INF;
    end else if (inf1_e) begin
      rsel = eb_e; out_case_nxt = CASE_ONLY_SECOND;
    end else if (inf2_e) begin
      rsel = ea_e; out_case_nxt = CASE_ONLY_FIRST;
    end else if (sel_e.small_a) begin
      if (sel_e.small_b) out_case_nxt = CASE_DEGENERATE;
      else begin
        rsel = tres[2]; out_case_nxt = CASE_LINEAR;
      end
    end else if (sel_e.neg_disc) begin
      out_case_nxt = CASE_NEG_DISC;
    end else if (sel_e.no_root) begin
      out_case_nxt = CASE_NO_ROOT;
    end else if (in1_e && in2_e) begin
      rsel = (tres[0] < tres[1]) ? tres[0] : tres[1];
      out_case_nxt = CASE_TWO_ROOTS;
    end else if (in1_e) begin
      rsel = tres[0]; out_case_nxt = CASE_ONE_ROOT;
    end else if (in2_e) begin
      rsel = tres[1]; out_case_nxt = CASE_ONE_ROOT;
    end
    rcl = rsel[63] ? 64'sd0 : rsel;
    if ((inf1_e && inf2_e) || (64'(rcl) >= VMASK64)) out_time_nxt = '1;
    else out_time_nxt = rcl[VW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_time_r <= out_time_nxt;
      out_case_r <= out_case_nxt;
    end
  end

  assign out_tvalid = vld_r[LAST];
  assign out_tdata  = OUT_W'(out_time_r);
  assign out_tuser  = out_case_r;

  // checks
  `ETLU_ASSERT_IMPL(a_stall_blocks_input, vld_r[LAST] && !out_tready, !in_tready, "input taken while output stalled")
  `ETLU_ASSERT_NEXT(a_transfer_enters, in_tvalid && in_tready, vld_r[0], "accepted transfer missing from pipe")
  `ETLU_ASSERT_IMPL(a_both_inf_time, out_tvalid && out_tuser == CASE_BOTH_INF, &out_time_r, "both unreached but finite time")

endmodule

@@ rtl/etlu_dly.sv @@
module etlu_dly #(
  parameter int W = 64,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sh_r [N];

  // shift line advancing with the pipe
  always_ff @(posedge clk) begin
    if (en) begin
      sh_r[0] <= d;
      for (int k = 1; k < N; k++) sh_r[k] <= sh_r[k-1];
    end
  end

  assign q = sh_r[N-1];

endmodule

@@ rtl/etlu_mul.sv @@
module etlu_mul import etlu_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic en,
  input  q_t   a,
  input  q_t   b,
  output q_t   p
);

  logic [63:0] ma, mb;
  logic [63:0] ll_r, lh_r, hl_r, hh_r;
  logic        neg_r;
  logic [127:0] full;
  logic [63:0]  rr, mag;
  logic         ovf;

  assign ma = qmag(a);
  assign mb = qmag(b);

  // stage 1: four 32x32 partial products
  always_ff @(posedge clk) begin
    if (en) begin
      ll_r  <= 64'(ma[31:0]) * 64'(mb[31:0]);
      lh_r  <= 64'(ma[31:0]) * 64'(mb[63:32]);
      hl_r  <= 64'(ma[63:32]) * 64'(mb[31:0]);
      hh_r  <= 64'(ma[63:32]) * 64'(mb[63:32]);
      neg_r <= a[63] != b[63];
    end
  end

  // stage 2: sum, drop fraction, saturate, apply sign
  always_comb begin
    full = {64'b0, ll_r} + {32'b0, lh_r, 32'b0} + {32'b0, hl_r, 32'b0} + {hh_r, 64'b0};
    ovf  = |full[127:FRAC_BITS+64];
    rr   = full[FRAC_BITS+63:FRAC_BITS];
    mag  = (ovf || rr[63]) ? 64'(QMAX) : rr;
  end

  always_ff @(posedge clk) begin
    if (en) p <= neg_r ? -$signed(mag) : $signed(mag);
  end

endmodule

@@ rtl/etlu_sqrt.sv @@
module etlu_sqrt import etlu_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic en,
  input  q_t   x,
  output q_t   y
);

  typedef struct packed {
    logic [87:0] xs;
    logic [47:0] rm;
    logic [43:0] rt;
  } sq_t;

  sq_t st_r [SQRT_STEPS];
  sq_t st_in [SQRT_STEPS];
  logic [63:0] ux;

  // negative operands read as zero; operand aligned to the fraction point
  assign ux = x[63] ? 64'd0 : 64'(x);

  // one result bit per stage
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam int I = SQRT_STEPS - 1 - k;
    logic [47:0] rs, tt;
    sq_t nx;
    if (k == 0) begin : g_first
      assign st_in[k] = '{xs: 88'(ux) << FRAC_BITS, rm: 48'd0, rt: 44'd0};
    end else begin : g_next
      assign st_in[k] = st_r[k-1];
    end
    always_comb begin
      nx = st_in[k];
      rs = {st_in[k].rm[45:0], st_in[k].xs[2*I+1], st_in[k].xs[2*I]};
      tt = {2'b0, st_in[k].rt, 2'b01};
      if (rs >= tt) begin
        nx.rm = rs - tt;
        nx.rt = {st_in[k].rt[42:0], 1'b1};
      end else begin
        nx.rm = rs;
        nx.rt = {st_in[k].rt[42:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (en) st_r[k] <= nx;
    end
  end

  assign y = $signed(64'(st_r[SQRT_STEPS-1].rt));

endmodule

@@ rtl/etlu_div.sv @@
module etlu_div import etlu_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic en,
  input  q_t   n,
  input  q_t   d,
  output q_t   q
);

  localparam int NS = 63 + FRAC_BITS;

  typedef struct packed {
    logic [62:0] mn;
    logic [63:0] md;
    logic [63:0] rm;
    logic [63:0] qt;
    logic        sat;
    logic        neg;
    logic        dz;
    logic        npos;
    logic        nneg;
  } dv_t;

  dv_t st_r [NS];
  dv_t st_in [NS];
  dv_t lst;
  logic [63:0] mn_full;

  assign mn_full = qmag(n);

  // one quotient bit per stage, frozen once it passes the saturation limit
  for (genvar k = 0; k < NS; k++) begin : g_step
    logic bitv;
    logic [63:0] rs, qs;
    dv_t nx;
    if (k == 0) begin : g_first
      assign st_in[k] = '{mn: mn_full[62:0], md: qmag(d), rm: 64'd0, qt: 64'd0,
                          sat: 1'b0, neg: n[63] != d[63], dz: d == 64'sd0,
                          npos: n > 64'sd0, nneg: n[63]};
    end else begin : g_next
      assign st_in[k] = st_r[k-1];
    end
    if (k <= 62) begin : g_bit
      assign bitv = st_in[k].mn[62-k];
    end else begin : g_zero
      assign bitv = 1'b0;
    end
    always_comb begin
      nx = st_in[k];
      rs = {st_in[k].rm[62:0], bitv};
      qs = {st_in[k].qt[62:0], 1'b0};
      if (!st_in[k].sat) begin
        if (rs >= st_in[k].md) begin
          rs = rs - st_in[k].md;
          qs = qs | 64'd1;
        end
        if (qs > 64'(QMAX)) begin
          qs = 64'(QMAX);
          nx.sat = 1'b1;
        end
        nx.rm = rs;
        nx.qt = qs;
      end
    end
    always_ff @(posedge clk) begin
      if (en) st_r[k] <= nx;
    end
  end

  // sign and divide-by-zero handling
  assign lst = st_r[NS-1];

  always_ff @(posedge clk) begin
    if (en) begin
      if (lst.dz) q <= lst.npos ? QMAX : (lst.nneg ? -QMAX : 64'sd0);
      else        q <= lst.neg ? -$signed(lst.qt) : $signed(lst.qt);
    end
  end

endmodule
